>>> rtl/core/ldra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldra_pkg: shared types and constants of the digital rain animator
// Item, result and register structs, register codes and random generator
// constants.
// ----------------------------------------------------------------------------
package ldra_pkg;

  localparam int IDX_W = 6;   // led index width
  localparam int CNT_W = 7;   // counters that can hold the led count itself
  localparam int DIV_N_W = 16;
  localparam int DIV_D_W = 8;

  localparam logic [31:0] LCG_MUL  = 32'd1103515245;
  localparam logic [31:0] LCG_INC  = 32'd12345;
  localparam logic [31:0] LCG_SEED = 32'h12345678;

  localparam logic [7:0] BRIGHTNESS_RST = 8'hff;
  localparam logic [7:0] SPREAD_RST     = 8'd12;
  localparam logic [7:0] PERIOD_RST     = 8'd28;
  localparam logic [7:0] CHANCE_RST     = 8'd24;

  // register codes on the configuration port
  typedef enum logic [1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_SPREAD     = 2'd1,
    REG_PERIOD     = 2'd2,
    REG_CHANCE     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] brightness;
    logic [7:0] column_spread;
    logic [7:0] drop_period;
    logic [7:0] drop_chance;
  } cfg_t;

  // classified item between front and back
  typedef struct packed {
    logic             is_frame;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [7:0]       x;
    logic [7:0]       y;
    logic             restart;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] pixel;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last;
  } result_t;

  // column list entry: led and its y
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [7:0]       y;
  } list_t;

endpackage

>>> rtl/core/ldra_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldra_fifo: two-entry queue
// Small register queue that parts a producer from a consumer.
// ----------------------------------------------------------------------------
module ldra_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

>>> rtl/core/ldra_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldra_front: item intake
// Classifies incoming items as loads or frames and queues them for the
// animation engine.
// ----------------------------------------------------------------------------
module ldra_front #(
  parameter int LED_COUNT = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic                         mode_i,
  input  logic [ldra_pkg::IDX_W-1:0]   led_index_i,
  input  logic [7:0]                   coord_x_i,
  input  logic [7:0]                   coord_y_i,
  input  logic                         restart_i,
  output ldra_pkg::cmd_t               cmd_o,
  output logic                         cmd_valid_o,
  input  logic                         cmd_pop_i
);
  import ldra_pkg::*;

  cmd_t cmd_in;
  logic cmd_empty;

  // classify the item
  always_comb begin
    cmd_in.is_frame = mode_i;
    cmd_in.in_range = {1'b0, led_index_i} < CNT_W'(LED_COUNT);
    cmd_in.idx      = led_index_i;
    cmd_in.x        = coord_x_i;
    cmd_in.y        = coord_y_i;
    cmd_in.restart  = restart_i;
  end

  ldra_fifo #(
    .Width($bits(cmd_t))
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cmd_in),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_o),
    .empty_o(cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

>>> rtl/core/ldra_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldra_div: iterative divider
// Restoring division, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module ldra_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ldra_pkg::DIV_N_W-1:0]  dividend_i,
  input  logic [ldra_pkg::DIV_D_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [ldra_pkg::DIV_N_W-1:0]  quot_o,
  output logic [ldra_pkg::DIV_D_W-1:0]  rem_o
);
  import ldra_pkg::*;

  localparam int CW = $clog2(DIV_N_W);

  logic               busy_q, done_q;
  logic [CW-1:0]      cnt_q;
  logic [DIV_N_W-1:0] quo_q;
  logic [DIV_D_W-1:0] rem_q, dvs_q;
  logic [DIV_D_W:0]   trial;
  logic               ge;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem_q, quo_q[DIV_N_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIV_N_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_N_W-2:0], ge};
      rem_q <= ge ? DIV_D_W'(trial - {1'b0, dvs_q}) : trial[DIV_D_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/core/ldra_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldra_engine: animation engine
// Sequencer over the led stores: coordinate loads, column grouping, head
// spawning, trail decay with colour output, and head moves per column.
// ----------------------------------------------------------------------------
module ldra_engine #(
  parameter int LED_COUNT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ldra_pkg::cfg_t    cfg_i,
  input  ldra_pkg::cmd_t    cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  output ldra_pkg::result_t res_o,
  output logic              res_push_o,
  input  logic              res_full_i
);
  import ldra_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_GRP_RD, ST_GRP_X, ST_GRP_ANC, ST_GRP_CMP,
    ST_TICKS, ST_TICKS_W,
    ST_SP_COL, ST_SP_MOD, ST_SP_MODW, ST_SP_SCAN, ST_SP_SET,
    ST_EM_RD, ST_EM_S, ST_EM_DIVW, ST_EM_OUT,
    ST_MV_COL, ST_MV_SCAN, ST_SA_RD, ST_SA_GET, ST_SB, ST_SA_END,
    ST_MJ_L, ST_MJ_I, ST_MJ_V, ST_MJ_END
  } state_e;

  localparam logic [CNT_W-1:0] LedCnt  = CNT_W'(LED_COUNT);
  localparam logic [CNT_W-1:0] LedLast = CNT_W'(LED_COUNT - 1);

  state_e           state_q;
  logic [CNT_W-1:0] i_q, c_q, total_q, n_q, a_q, b_q;
  logic [7:0]       x_q, top_y_q, ticks_q, drop_cnt_q, decay_cnt_q;
  logic [7:0]       prev_val_q, red_q, green_q;
  logic [IDX_W-1:0] top_idx_q, scan_idx_q, cur_idx_q, prev_idx_q;
  logic             have_q, scan_vld_q, first_q, sel_red_q;
  logic [31:0]      lcg_q;
  list_t            cur_q;

  // stores
  logic [15:0]      pos_mem  [LED_COUNT];
  logic [IDX_W-1:0] col_mem  [LED_COUNT];
  logic [7:0]       anc_mem  [LED_COUNT];
  logic [7:0]       int_mem  [LED_COUNT];
  list_t            list_mem [LED_COUNT];
  logic [LED_COUNT-1:0] int_vld_q;

  logic [15:0]      pos_rd_q;
  logic [IDX_W-1:0] col_rd_q;
  logic [7:0]       anc_rd_q, int_rd_q;
  logic             int_rd_vld_q;
  list_t            list_rd_q;

  logic [IDX_W-1:0] scan_addr, anc_raddr, int_raddr, list_raddr;
  logic             pos_we, col_we, anc_we, int_we, list_we, int_clr;
  logic [IDX_W-1:0] pos_waddr, col_waddr, anc_waddr, int_waddr, list_waddr;
  logic [15:0]      pos_wdata;
  logic [IDX_W-1:0] col_wdata;
  logic [7:0]       anc_wdata, int_wdata;
  list_t            list_wdata;

  // divider hookup
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_dividend, div_quot;
  logic [DIV_D_W-1:0] div_divisor, div_rem;

  // derived levels
  logic [7:0] full, green_lvl, int_val, em_s, anc_diff;
  logic [9:0] full_x3;
  logic       em_dec, em_hi, scan_match, scan_better, grp_last, swap;

  assign full      = cfg_i.brightness;
  assign full_x3   = {2'b0, full} + {1'b0, full, 1'b0};
  assign green_lvl = full_x3[9:2];
  assign int_val   = int_rd_vld_q ? int_rd_q : 8'd0;

  // emit step: decay then colour class
  assign em_dec = (int_val != 8'd0) && (int_val < full) && (decay_cnt_q >= ticks_q);
  assign em_s   = em_dec ? int_val - 8'd1 : int_val;
  assign em_hi  = em_s > green_lvl;

  // scans over the leds of column c
  assign scan_match  = scan_vld_q && (col_rd_q == c_q[IDX_W-1:0]);
  assign scan_better = !have_q || (pos_rd_q[7:0] < top_y_q);
  assign anc_diff    = (anc_rd_q > x_q) ? anc_rd_q - x_q : x_q - anc_rd_q;
  assign grp_last    = i_q == LedLast;
  assign swap        = scan_vld_q && (cur_q.y < list_rd_q.y);

  // store addressing and write ports
  always_comb begin
    scan_addr  = i_q[IDX_W-1:0];
    anc_raddr  = c_q[IDX_W-1:0];
    int_raddr  = i_q[IDX_W-1:0];
    list_raddr = a_q[IDX_W-1:0];
    pos_we = 1'b0; pos_waddr = cmd_i.idx; pos_wdata = {cmd_i.x, cmd_i.y};
    col_we = 1'b0; col_waddr = i_q[IDX_W-1:0]; col_wdata = c_q[IDX_W-1:0];
    anc_we = 1'b0; anc_waddr = c_q[IDX_W-1:0]; anc_wdata = x_q;
    int_we = 1'b0; int_waddr = prev_idx_q; int_wdata = prev_val_q;
    list_we = 1'b0; list_waddr = a_q[IDX_W-1:0]; list_wdata = cur_q;
    int_clr = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pos_we = cmd_valid_i && !cmd_i.is_frame && cmd_i.in_range;
      end
      ST_GRP_ANC: begin
        if (c_q == total_q) begin
          anc_we = 1'b1;
          col_we = 1'b1;
          int_clr = grp_last;
        end
      end
      ST_GRP_CMP: begin
        if (anc_diff <= cfg_i.column_spread) begin
          col_we = 1'b1;
          int_clr = grp_last;
        end
      end
      ST_SP_SET: begin
        int_we = have_q;
        int_waddr = top_idx_q;
        int_wdata = full;
      end
      ST_EM_S: begin
        int_we = em_dec;
        int_waddr = i_q[IDX_W-1:0];
        int_wdata = em_s;
      end
      ST_MV_SCAN: begin
        list_we = scan_match;
        list_waddr = n_q[IDX_W-1:0];
        list_wdata = '{idx: scan_idx_q, y: pos_rd_q[7:0]};
      end
      ST_SB: begin
        list_raddr = b_q[IDX_W-1:0];
        list_we = swap;
        list_waddr = scan_idx_q;
      end
      ST_SA_END: list_we = 1'b1;
      ST_MJ_I: int_raddr = list_rd_q.idx;
      ST_MJ_V: begin
        int_we = !first_q;
        int_wdata = (int_val >= full) ? full : prev_val_q;
      end
      ST_MJ_END: int_we = 1'b1;
      default: ;
    endcase
  end

  // coordinate store
  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rd_q <= pos_mem[scan_addr];
  end

  // column of each led
  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_waddr] <= col_wdata;
    col_rd_q <= col_mem[scan_addr];
  end

  // column anchors
  always_ff @(posedge clk_i) begin
    if (anc_we) anc_mem[anc_waddr] <= anc_wdata;
    anc_rd_q <= anc_mem[anc_raddr];
  end

  // intensity store
  always_ff @(posedge clk_i) begin
    if (int_we) int_mem[int_waddr] <= int_wdata;
    int_rd_q <= int_mem[int_raddr];
  end

  // intensity valid bits, an invalid entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_vld_q    <= '0;
      int_rd_vld_q <= 1'b0;
    end else begin
      if (int_clr) int_vld_q <= '0;
      else if (int_we) int_vld_q[int_waddr] <= 1'b1;
      int_rd_vld_q <= int_vld_q[int_raddr];
    end
  end

  // per-column ordering list
  always_ff @(posedge clk_i) begin
    if (list_we) list_mem[list_waddr] <= list_wdata;
    list_rd_q <= list_mem[list_raddr];
  end

  // divider operand selection
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {8'd0, lcg_q[23:16]};
    div_divisor  = cfg_i.drop_chance;
    case (state_q)
      ST_TICKS: begin
        div_start    = full != 8'd0;
        div_dividend = DIV_N_W'(8'hff);
        div_divisor  = full;
      end
      ST_SP_MOD: div_start = 1'b1;
      ST_EM_S: begin
        if (em_hi) begin
          div_start    = 1'b1;
          div_dividend = DIV_N_W'(green_lvl) * DIV_N_W'(em_s - green_lvl);
          div_divisor  = (full > green_lvl) ? full - green_lvl : 8'd1;
        end else begin
          div_start    = green_lvl != 8'd0;
          div_dividend = DIV_N_W'(full) * DIV_N_W'(em_s);
          div_divisor  = green_lvl;
        end
      end
      default: ;
    endcase
  end

  ldra_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign cmd_pop_o  = (state_q == ST_IDLE) && cmd_valid_i;
  assign res_push_o = (state_q == ST_EM_OUT) && !res_full_i;
  assign res_o = '{pixel: i_q[IDX_W-1:0], red: red_q, green: green_q, blue: red_q,
                   last: i_q == LedLast};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      c_q         <= '0;
      total_q     <= '0;
      n_q         <= '0;
      a_q         <= '0;
      b_q         <= '0;
      have_q      <= 1'b0;
      scan_vld_q  <= 1'b0;
      first_q     <= 1'b0;
      sel_red_q   <= 1'b0;
      ticks_q     <= 8'hff;
      drop_cnt_q  <= '0;
      decay_cnt_q <= '0;
      lcg_q       <= LCG_SEED;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i && cmd_i.is_frame) begin
            i_q <= '0;
            if (cmd_i.restart) begin
              total_q <= '0;
              state_q <= ST_GRP_RD;
            end else begin
              state_q <= ST_TICKS;
            end
          end
        end
        // column grouping
        ST_GRP_RD: state_q <= ST_GRP_X;
        ST_GRP_X: begin
          x_q     <= pos_rd_q[15:8];
          c_q     <= '0;
          state_q <= ST_GRP_ANC;
        end
        ST_GRP_ANC: begin
          if (c_q == total_q) begin
            total_q <= total_q + 1'b1;
            i_q     <= i_q + 1'b1;
            state_q <= ST_GRP_RD;
            if (grp_last) begin
              drop_cnt_q  <= '0;
              decay_cnt_q <= '0;
              state_q     <= ST_TICKS;
            end
          end else begin
            state_q <= ST_GRP_CMP;
          end
        end
        ST_GRP_CMP: begin
          if (anc_diff <= cfg_i.column_spread) begin
            i_q     <= i_q + 1'b1;
            state_q <= ST_GRP_RD;
            if (grp_last) begin
              drop_cnt_q  <= '0;
              decay_cnt_q <= '0;
              state_q     <= ST_TICKS;
            end
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= ST_GRP_ANC;
          end
        end
        // decay rate
        ST_TICKS: begin
          decay_cnt_q <= decay_cnt_q + 8'd1;
          c_q <= '0;
          i_q <= '0;
          if (full == 8'd0) begin
            ticks_q <= 8'hff;
            state_q <= (drop_cnt_q == 8'd0) ? ST_SP_COL : ST_EM_RD;
          end else begin
            state_q <= ST_TICKS_W;
          end
        end
        ST_TICKS_W: begin
          if (div_done) begin
            ticks_q <= div_quot[7:0];
            state_q <= (drop_cnt_q == 8'd0) ? ST_SP_COL : ST_EM_RD;
          end
        end
        // head spawning
        ST_SP_COL: begin
          i_q <= '0;
          have_q <= 1'b0;
          scan_vld_q <= 1'b0;
          if (c_q == total_q) begin
            state_q <= ST_EM_RD;
          end else if (cfg_i.drop_chance == 8'd0) begin
            state_q <= ST_SP_SCAN;
          end else begin
            lcg_q   <= lcg_q * LCG_MUL + LCG_INC;
            state_q <= ST_SP_MOD;
          end
        end
        ST_SP_MOD: state_q <= ST_SP_MODW;
        ST_SP_MODW: begin
          if (div_done) begin
            if (div_rem == '0) begin
              state_q <= ST_SP_SCAN;
            end else begin
              c_q     <= c_q + 1'b1;
              state_q <= ST_SP_COL;
            end
          end
        end
        ST_SP_SCAN: begin
          scan_vld_q <= i_q < LedCnt;
          scan_idx_q <= i_q[IDX_W-1:0];
          if (i_q < LedCnt) i_q <= i_q + 1'b1;
          if (scan_match && scan_better) begin
            have_q    <= 1'b1;
            top_y_q   <= pos_rd_q[7:0];
            top_idx_q <= scan_idx_q;
          end
          if (i_q == LedCnt && !scan_vld_q) state_q <= ST_SP_SET;
        end
        ST_SP_SET: begin
          c_q     <= c_q + 1'b1;
          state_q <= ST_SP_COL;
        end
        // decay and colour output
        ST_EM_RD: state_q <= ST_EM_S;
        ST_EM_S: begin
          if (em_hi) begin
            green_q   <= full;
            sel_red_q <= 1'b1;
            state_q   <= ST_EM_DIVW;
          end else begin
            red_q     <= '0;
            sel_red_q <= 1'b0;
            if (green_lvl != 8'd0) begin
              state_q <= ST_EM_DIVW;
            end else begin
              green_q <= '0;
              state_q <= ST_EM_OUT;
            end
          end
        end
        ST_EM_DIVW: begin
          if (div_done) begin
            if (sel_red_q) red_q <= div_quot[7:0];
            else green_q <= div_quot[7:0];
            state_q <= ST_EM_OUT;
          end
        end
        ST_EM_OUT: begin
          if (!res_full_i) begin
            i_q     <= i_q + 1'b1;
            state_q <= ST_EM_RD;
            if (i_q == LedLast) begin
              c_q <= '0;
              if (decay_cnt_q >= ticks_q) decay_cnt_q <= '0;
              if (drop_cnt_q >= cfg_i.drop_period) begin
                drop_cnt_q <= '0;
                state_q    <= (full != 8'd0) ? ST_MV_COL : ST_IDLE;
              end else begin
                drop_cnt_q <= drop_cnt_q + 8'd1;
                state_q    <= ST_IDLE;
              end
            end
          end
        end
        // head moves: gather the column
        ST_MV_COL: begin
          i_q <= '0;
          n_q <= '0;
          scan_vld_q <= 1'b0;
          state_q <= (c_q == total_q) ? ST_IDLE : ST_MV_SCAN;
        end
        ST_MV_SCAN: begin
          scan_vld_q <= i_q < LedCnt;
          scan_idx_q <= i_q[IDX_W-1:0];
          if (i_q < LedCnt) i_q <= i_q + 1'b1;
          if (scan_match) n_q <= n_q + 1'b1;
          if (i_q == LedCnt && !scan_vld_q) begin
            a_q <= '0;
            if (n_q == '0) begin
              c_q     <= c_q + 1'b1;
              state_q <= ST_MV_COL;
            end else begin
              state_q <= ST_SA_RD;
            end
          end
        end
        // exchange ordering, lowest led first
        ST_SA_RD: begin
          if (a_q + 1'b1 >= n_q) begin
            a_q     <= '0;
            first_q <= 1'b1;
            state_q <= ST_MJ_L;
          end else begin
            state_q <= ST_SA_GET;
          end
        end
        ST_SA_GET: begin
          cur_q      <= list_rd_q;
          b_q        <= a_q + 1'b1;
          scan_vld_q <= 1'b0;
          state_q    <= ST_SB;
        end
        ST_SB: begin
          scan_vld_q <= b_q < n_q;
          scan_idx_q <= b_q[IDX_W-1:0];
          if (b_q < n_q) b_q <= b_q + 1'b1;
          if (swap) cur_q <= list_rd_q;
          if (b_q == n_q && !scan_vld_q) state_q <= ST_SA_END;
        end
        ST_SA_END: begin
          a_q     <= a_q + 1'b1;
          state_q <= ST_SA_RD;
        end
        // shift heads one led down
        ST_MJ_L: state_q <= ST_MJ_I;
        ST_MJ_I: begin
          cur_idx_q <= list_rd_q.idx;
          state_q   <= ST_MJ_V;
        end
        ST_MJ_V: begin
          first_q    <= 1'b0;
          prev_idx_q <= cur_idx_q;
          if (first_q) begin
            prev_val_q <= (int_val == full) ? int_val - 8'd1 : int_val;
          end else begin
            prev_val_q <= (int_val >= full) ? full - 8'd1 : int_val;
          end
          a_q     <= a_q + 1'b1;
          state_q <= (a_q + 1'b1 == n_q) ? ST_MJ_END : ST_MJ_L;
        end
        ST_MJ_END: begin
          c_q     <= c_q + 1'b1;
          state_q <= ST_MV_COL;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/led_digital_rain_animator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_digital_rain_animator: falling-green led animation
// Coordinate loads and frame renders in, one colour per led out.
// ----------------------------------------------------------------------------
// A frame walks the stores in one sequencer: decay and colour for each
// led, most of it spent in the shared divider; when the drop counter is
// zero, a random draw per column plus a scan of all leds for each column
// that spawns; on a move frame, per column a scan to gather its leds, an
// ordering of those leds and the shift. A restart adds grouping through
// the anchor store. The intensity store clears at once through valid bits,
// so there is no clearing pass. Results wait in a two-entry queue, so the
// engine stalls only when that queue is full.
module led_digital_rain_animator #(
  parameter int LED_COUNT = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // item queue
  input  logic                       push,
  output logic                       full,
  input  logic                       mode_i,
  input  logic [ldra_pkg::IDX_W-1:0] led_index_i,
  input  logic [7:0]                 coord_x_i,
  input  logic [7:0]                 coord_y_i,
  input  logic                       restart_i,
  // result queue
  output logic                       empty,
  input  logic                       pop,
  output logic [ldra_pkg::IDX_W-1:0] pixel_o,
  output logic [7:0]                 red_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 blue_o,
  output logic                       last_o,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ldra_pkg::*;

  cfg_t     cfg_q;
  cmd_t     cmd;
  result_t  res_in, res_out;
  logic     cmd_valid, cmd_pop, res_push, res_full;
  reg_idx_e reg_sel;

  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness    <= BRIGHTNESS_RST;
      cfg_q.column_spread <= SPREAD_RST;
      cfg_q.drop_period   <= PERIOD_RST;
      cfg_q.drop_chance   <= CHANCE_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_BRIGHTNESS: cfg_q.brightness    <= pwdata[7:0];
        REG_SPREAD:     cfg_q.column_spread <= pwdata[7:0];
        REG_PERIOD:     cfg_q.drop_period   <= pwdata[7:0];
        REG_CHANCE:     cfg_q.drop_chance   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_sel)
      REG_BRIGHTNESS: prdata = {24'd0, cfg_q.brightness};
      REG_SPREAD:     prdata = {24'd0, cfg_q.column_spread};
      REG_PERIOD:     prdata = {24'd0, cfg_q.drop_period};
      REG_CHANCE:     prdata = {24'd0, cfg_q.drop_chance};
      default:        prdata = '0;
    endcase
  end

  ldra_front #(
    .LED_COUNT(LED_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .mode_i     (mode_i),
    .led_index_i(led_index_i),
    .coord_x_i  (coord_x_i),
    .coord_y_i  (coord_y_i),
    .restart_i  (restart_i),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop)
  );

  ldra_engine #(
    .LED_COUNT(LED_COUNT)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .res_o      (res_in),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  // result queue
  ldra_fifo #(
    .Width($bits(result_t))
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign pixel_o = res_out.pixel;
  assign red_o   = res_out.red;
  assign green_o = res_out.green;
  assign blue_o  = res_out.blue;
  assign last_o  = res_out.last;

endmodule
